FILE: design/ctt_pkg.sv
package ctt_pkg;

  localparam int LINE_BITS = 16;
  localparam int MAX_NEST = 15;
  localparam int NEST_BITS = $clog2(MAX_NEST + 1);
  localparam int OUT_LINE_MAX = 65535;

  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_WORD_BYTE = 2'd0;
  localparam logic [1:0] KIND_WORD_END = 2'd1;
  localparam logic [1:0] KIND_OPEN_COMMENT = 2'd2;
  localparam logic [1:0] KIND_END_TEXT = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] chr;
    logic [15:0] line;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t [2:0] r;
  } group_t;

  function automatic logic [15:0] clamp_line(input logic [LINE_BITS-1:0] v);
    logic [LINE_BITS+16:0] w;
    w = (LINE_BITS + 17)'(v);
    if (w > (LINE_BITS + 17)'(OUT_LINE_MAX)) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

endpackage

FILE: design/ctt_front.sv
module ctt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_text_byte,
  input  logic            q_full,
  output logic            push,
  output ctt_pkg::group_t grp
);

  localparam logic [1:0] MODE_BETWEEN = 2'd0;
  localparam logic [1:0] MODE_WORD = 2'd1;
  localparam logic [1:0] MODE_LINEC = 2'd2;
  localparam logic [1:0] MODE_BLOCK = 2'd3;

  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_NL = 8'h0A;

  localparam logic [ctt_pkg::LINE_BITS-1:0] LINE_MAX = '1;
  localparam logic [ctt_pkg::LINE_BITS-1:0] LINE_ONE = ctt_pkg::LINE_BITS'(1);
  localparam logic [ctt_pkg::NEST_BITS-1:0] NEST_MAX =
    ctt_pkg::NEST_BITS'(ctt_pkg::MAX_NEST);
  localparam logic [ctt_pkg::NEST_BITS-1:0] NEST_ONE = ctt_pkg::NEST_BITS'(1);

  logic [1:0] mode_r, mode_nxt;
  logic slash_r, slash_nxt;
  logic star_r, star_nxt;
  logic [ctt_pkg::NEST_BITS-1:0] nest_r, nest_nxt;
  logic [ctt_pkg::LINE_BITS-1:0] line_r, line_nxt;
  logic [ctt_pkg::LINE_BITS-1:0] open_r, open_nxt;
  logic accept;
  ctt_pkg::group_t g;

  function automatic ctt_pkg::res_t mk(input logic [1:0] k, input logic [7:0] ch,
                                       input logic [15:0] ln);
    ctt_pkg::res_t r;
    r.kind = k;
    r.chr = ch;
    r.line = ln;
    return r;
  endfunction

  assign accept = in_valid && !q_full;

  always_comb begin
    logic [1:0] n;
    logic [7:0] c;
    logic [15:0] ln;
    logic [ctt_pkg::LINE_BITS-1:0] bumped;
    logic plain;
    n = 2'd0;
    c = in_text_byte;
    ln = ctt_pkg::clamp_line(line_r);
    bumped = (line_r != LINE_MAX) ? line_r + LINE_ONE : line_r;
    plain = 1'b0;
    g = '0;
    mode_nxt = mode_r;
    slash_nxt = slash_r;
    star_nxt = star_r;
    nest_nxt = nest_r;
    line_nxt = line_r;
    open_nxt = open_r;
    if (c == CH_NUL) begin
      if (mode_r == MODE_BLOCK) begin
        g.r[n] = mk(ctt_pkg::KIND_OPEN_COMMENT, 8'd0, ctt_pkg::clamp_line(open_r));
        n = n + 2'd1;
      end else if (mode_r != MODE_LINEC) begin
        if (slash_r) begin
          g.r[n] = mk(ctt_pkg::KIND_WORD_BYTE, CH_SLASH, ln);
          n = n + 2'd1;
        end
        if (slash_r || mode_r == MODE_WORD) begin
          g.r[n] = mk(ctt_pkg::KIND_WORD_END, 8'd0, ln);
          n = n + 2'd1;
        end
      end
      g.r[n] = mk(ctt_pkg::KIND_END_TEXT, 8'd0, ln);
      n = n + 2'd1;
      mode_nxt = MODE_BETWEEN;
      slash_nxt = 1'b0;
      star_nxt = 1'b0;
      nest_nxt = '0;
      line_nxt = LINE_ONE;
      open_nxt = '0;
    end else if (mode_r == MODE_BLOCK) begin
      if (star_r && c == CH_SLASH) begin
        star_nxt = 1'b0;
        if (nest_r <= NEST_ONE) begin
          nest_nxt = '0;
          mode_nxt = MODE_BETWEEN;
        end else begin
          nest_nxt = nest_r - NEST_ONE;
        end
      end else if (slash_r && c == CH_STAR) begin
        slash_nxt = 1'b0;
        if (nest_r < NEST_MAX) begin
          nest_nxt = nest_r + NEST_ONE;
        end
      end else begin
        star_nxt = (c == CH_STAR);
        slash_nxt = (c == CH_SLASH);
        if (c == CH_NL) begin
          line_nxt = bumped;
        end
      end
    end else if (mode_r == MODE_LINEC) begin
      if (c == CH_NL) begin
        line_nxt = bumped;
        mode_nxt = MODE_BETWEEN;
      end
    end else if (slash_r) begin
      slash_nxt = 1'b0;
      if (c == CH_SLASH || c == CH_STAR) begin
        if (mode_r == MODE_WORD) begin
          g.r[n] = mk(ctt_pkg::KIND_WORD_END, 8'd0, ln);
          n = n + 2'd1;
        end
        if (c == CH_SLASH) begin
          mode_nxt = MODE_LINEC;
        end else begin
          mode_nxt = MODE_BLOCK;
          nest_nxt = NEST_ONE;
          star_nxt = 1'b0;
          open_nxt = line_r;
        end
      end else begin
        g.r[n] = mk(ctt_pkg::KIND_WORD_BYTE, CH_SLASH, ln);
        n = n + 2'd1;
        mode_nxt = MODE_WORD;
        plain = 1'b1;
      end
    end else begin
      plain = 1'b1;
    end
    if (plain) begin
      if (c inside {8'd32, [8'd9:8'd13]}) begin
        if (mode_nxt == MODE_WORD) begin
          g.r[n] = mk(ctt_pkg::KIND_WORD_END, 8'd0, ln);
          n = n + 2'd1;
        end
        mode_nxt = MODE_BETWEEN;
        if (c == CH_NL) begin
          line_nxt = bumped;
        end
      end else if (c == CH_SLASH) begin
        slash_nxt = 1'b1;
      end else begin
        g.r[n] = mk(ctt_pkg::KIND_WORD_BYTE, c, ln);
        n = n + 2'd1;
        mode_nxt = MODE_WORD;
      end
    end
    g.cnt = n;
  end

  assign grp = g;
  assign push = accept && (g.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BETWEEN;
      slash_r <= 1'b0;
      star_r <= 1'b0;
      nest_r <= '0;
      line_r <= LINE_ONE;
      open_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      slash_r <= slash_nxt;
      star_r <= star_nxt;
      nest_r <= nest_nxt;
      line_r <= line_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

FILE: design/ctt_queue.sv
module ctt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ctt_pkg::group_t grp,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_out_byte,
  output logic [15:0]     out_line,
  output logic            out_last
);

  localparam logic [ctt_pkg::QCNT_BITS-1:0] QFULL =
    ctt_pkg::QCNT_BITS'(ctt_pkg::QDEPTH);
  localparam logic [ctt_pkg::QCNT_BITS-1:0] QONE = ctt_pkg::QCNT_BITS'(1);
  localparam logic [ctt_pkg::QPTR_BITS-1:0] PONE = ctt_pkg::QPTR_BITS'(1);

  ctt_pkg::group_t q_r [ctt_pkg::QDEPTH];
  logic [ctt_pkg::QPTR_BITS-1:0] wr_r, wr_nxt;
  logic [ctt_pkg::QPTR_BITS-1:0] rd_r, rd_nxt;
  logic [ctt_pkg::QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  ctt_pkg::group_t head;
  ctt_pkg::res_t cur;
  logic take;
  logic pop;

  assign head = q_r[rd_r];
  assign cur = head.r[idx_r];
  assign full = (cnt_r == QFULL);
  assign out_valid = (cnt_r != '0);
  assign out_kind = cur.kind;
  assign out_out_byte = cur.chr;
  assign out_line = cur.line;
  assign out_last = (idx_r == head.cnt - 2'd1);

  assign take = out_valid && !out_stall;
  assign pop = take && out_last;

  always_comb begin
    wr_nxt = push ? wr_r + PONE : wr_r;
    rd_nxt = pop ? rd_r + PONE : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QONE;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QONE;
    end
    idx_nxt = idx_r;
    if (pop) begin
      idx_nxt = 2'd0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
      idx_r <= 2'd0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("group written into a full queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QFULL) else $error("queue occupancy out of range");

  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (head.cnt != 2'd0 && idx_r < head.cnt))
    else $error("head group slot index out of range");

  a_idx_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> idx_r == 2'd0) else $error("slot index left behind on empty queue");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid) else $error("written group not visible");
`endif

endmodule

FILE: design/config_text_tokenizer_unit.sv
// Configuration text tokenizer.
// Input channel: one text byte per request on in_text_byte; byte 0 ends the
// text. A request is taken at a clock edge where in_valid is high and
// in_stall is low.
// Output channel: one result per request with out_kind, out_out_byte, out_line
// and out_last, taken where out_valid is high and out_stall is low. out_last
// marks the final result caused by one input byte.
// Each input byte gives zero to three results. The front end classifies one
// byte per cycle while the queue is not full and writes its results as one
// group into a four-entry queue. The back end drains the queue one result per
// cycle while out_stall is low. A byte's results are registered in the queue
// before they reach the output. Bytes are taken one per cycle while out_stall
// is low and bytes give at most one result each; a byte with two or three
// results holds the head of the queue until each of them is taken.
// When the receiver stalls, results stay stable and the queue fills; in_stall
// rises once all four entries hold groups.
// Reset clears the queue and returns the tokenizer to line 1, between words.
module config_text_tokenizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_out_byte,
  output logic [15:0] out_line,
  output logic        out_last
);

  logic q_full;
  logic push;
  ctt_pkg::group_t grp;

  assign in_stall = q_full;

  ctt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_text_byte (in_text_byte),
    .q_full       (q_full),
    .push         (push),
    .grp          (grp)
  );

  ctt_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .grp          (grp),
    .full         (q_full),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_out_byte (out_out_byte),
    .out_line     (out_line),
    .out_last     (out_last)
  );

endmodule
